### src/sfcc_pkg.sv
// Shared constants and types for the sensor frame CRC checker.
package sfcc_pkg;

   localparam int BYTE_W   = 8;
   localparam int CRC_W    = 16;
   localparam int WORD_W   = 16;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 8;
   localparam int RSP_W    = 56;

   localparam logic [CRC_W-1:0] CRC_START = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY  = 16'hA001;
   localparam logic [POS_W-1:0] POS_MAX   = 8'd255;

   localparam logic [POS_W-1:0] POS_HUM_HI  = 8'd2;
   localparam logic [POS_W-1:0] POS_HUM_LO  = 8'd3;
   localparam logic [POS_W-1:0] POS_TEMP_HI = 8'd4;
   localparam logic [POS_W-1:0] POS_TEMP_LO = 8'd5;
   localparam logic [POS_W-1:0] POS_CRC_MIN = 8'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CRC_ERR  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SENSE = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   humidity_tenths;
      logic [WORD_W-1:0]   temperature_tenths;
      logic [CRC_W-1:0]    computed_crc;
   } frame_result_type;

endpackage

### src/sfcc_crc_step.sv
// One byte of the reflected CRC-16 update, eight bit steps unrolled.
module sfcc_crc_step (
   input  logic [sfcc_pkg::CRC_W-1:0]  crc_in,
   input  logic [sfcc_pkg::BYTE_W-1:0] data_in,
   output logic [sfcc_pkg::CRC_W-1:0]  crc_out
);

   always_comb begin
      logic [sfcc_pkg::CRC_W-1:0] acc;
      acc = crc_in ^ {{(sfcc_pkg::CRC_W - sfcc_pkg::BYTE_W){1'b0}}, data_in};
      for (int k = 0; k < sfcc_pkg::BYTE_W; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ sfcc_pkg::CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_out = acc;
   end

endmodule

### src/sfcc_frame_state.sv
// Per-frame state: CRC accumulator, two-byte delay, position, captures, fault flag.
module sfcc_frame_state (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [sfcc_pkg::BYTE_W-1:0]    data_byte,
   input  logic                           last_byte,
   input  logic                           bus_fault,
   output sfcc_pkg::frame_result_type     result
);

   logic [sfcc_pkg::CRC_W-1:0]  crc_ff, crc_in;
   logic [sfcc_pkg::BYTE_W-1:0] held0_ff, held0_in;
   logic [sfcc_pkg::BYTE_W-1:0] held1_ff, held1_in;
   logic [sfcc_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [sfcc_pkg::WORD_W-1:0] hum_ff, hum_in;
   logic [sfcc_pkg::WORD_W-1:0] temp_ff, temp_in;
   logic                        fault_ff, fault_in;

   logic [sfcc_pkg::CRC_W-1:0]  crc_fed;
   logic [sfcc_pkg::CRC_W-1:0]  crc_next;
   logic [sfcc_pkg::WORD_W-1:0] hum_next, temp_next;
   logic                        fault_next;
   logic                        crc_match;

   sfcc_crc_step u_crc_step (
      .crc_in  (crc_ff),
      .data_in (held0_ff),
      .crc_out (crc_fed)
   );

   always_comb begin
      // the oldest held byte is clear of the trailer pair only once two bytes follow it
      crc_next   = (pos_ff >= sfcc_pkg::POS_CRC_MIN) ? crc_fed : crc_ff;
      fault_next = fault_ff | bus_fault;
      hum_next   = hum_ff;
      temp_next  = temp_ff;
      case (pos_ff)
         sfcc_pkg::POS_HUM_HI:  hum_next  = {data_byte, hum_ff[7:0]};
         sfcc_pkg::POS_HUM_LO:  hum_next  = {hum_ff[15:8], data_byte};
         sfcc_pkg::POS_TEMP_HI: temp_next = {data_byte, temp_ff[7:0]};
         sfcc_pkg::POS_TEMP_LO: temp_next = {temp_ff[15:8], data_byte};
         default: ;
      endcase

      crc_match = (held1_ff == crc_next[7:0]) && (data_byte == crc_next[15:8]);

      if (fault_next) begin
         result.status = sfcc_pkg::STATUS_NO_SENSE;
      end else if (pos_ff < sfcc_pkg::POS_CRC_MIN) begin
         result.status = sfcc_pkg::STATUS_CRC_ERR;
      end else if (crc_match) begin
         result.status = sfcc_pkg::STATUS_OK;
      end else begin
         result.status = sfcc_pkg::STATUS_CRC_ERR;
      end
      result.humidity_tenths    = hum_next;
      result.temperature_tenths = temp_next;
      result.computed_crc       = crc_next;

      crc_in   = crc_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      pos_in   = pos_ff;
      hum_in   = hum_ff;
      temp_in  = temp_ff;
      fault_in = fault_ff;
      if (step) begin
         if (last_byte) begin
            // frame done: return to the idle values
            crc_in   = sfcc_pkg::CRC_START;
            held0_in = '0;
            held1_in = '0;
            pos_in   = '0;
            hum_in   = '0;
            temp_in  = '0;
            fault_in = 1'b0;
         end else begin
            crc_in   = crc_next;
            held0_in = held1_ff;
            held1_in = data_byte;
            pos_in   = (pos_ff < sfcc_pkg::POS_MAX) ? pos_ff + 1'b1 : pos_ff;
            hum_in   = hum_next;
            temp_in  = temp_next;
            fault_in = fault_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= sfcc_pkg::CRC_START;
         held0_ff <= '0;
         held1_ff <= '0;
         pos_ff   <= '0;
         hum_ff   <= '0;
         temp_ff  <= '0;
         fault_ff <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         pos_ff   <= pos_in;
         hum_ff   <= hum_in;
         temp_ff  <= temp_in;
         fault_ff <= fault_in;
      end
   end

endmodule

### src/sensor_frame_crc_checker_unit.sv
// Top level of the sensor frame CRC checker: input register, frame state, result register.
//
// Usage:
//   req_* carries the response frame of the humidity/temperature sensor, one byte
//   per transaction: req_tdata = byte, req_tlast marks the final byte, req_tuser
//   flags a missed bus acknowledge (sticky over the frame).
//   rsp_* carries one transaction per frame, issued for the final byte: status,
//   raw humidity and temperature words (tenths) and the CRC-16 computed over all
//   bytes but the trailing two, which are compared against it low byte first.
// Path: a final byte accepted into the input register moves on into the result register
//   once that register is free, and from there shows on rsp_*.
// Throughput: one byte per cycle unless a final byte waits on a held result; the CRC
//   byte update is eight unrolled bit steps between input and frame state registers.
// Reset: synchronous, active high; empties both registers and returns the frame
//   state to its start (CRC 0xFFFF, position 0, captures 0, no fault).
// Stall: while rsp_tready is low, a pending result holds; non-final bytes keep
//   flowing, and a final byte waits in the input register, which backs up req_*
//   only once that register is occupied.
module sensor_frame_crc_checker_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sfcc_pkg::BYTE_W-1:0]    req_tdata,   // [7:0] data_byte
   input  logic                           req_tlast,   // last_byte
   input  logic                           req_tuser,   // [0] bus_fault
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sfcc_pkg::RSP_W-1:0]     rsp_tdata    // [1:0] status, [17:2] humidity_tenths,
                                                       // [33:18] temperature_tenths,
                                                       // [49:34] computed_crc, [55:50] zero
);

   // input register
   logic                        in_valid_ff, in_valid_in;
   logic [sfcc_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        in_last_ff;
   logic                        in_fault_ff;

   // result register
   logic                        out_valid_ff, out_valid_in;
   sfcc_pkg::frame_result_type  out_result_ff;

   sfcc_pkg::frame_result_type  frame_result;
   logic                        out_free;
   logic                        advance;
   logic                        take;

   // advance the held byte into the frame state; a final byte needs a free result slot
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   sfcc_frame_state u_frame_state (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .bus_fault (in_fault_ff),
      .result    (frame_result)
   );

   always_comb begin
      in_valid_in = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: input fields load on acceptance, the result loads when a final byte advances; hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff  <= req_tdata;
         in_last_ff  <= req_tlast;
         in_fault_ff <= req_tuser;
      end
      if (advance && in_last_ff) begin
         out_result_ff <= frame_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0,
                        out_result_ff.computed_crc,
                        out_result_ff.temperature_tenths,
                        out_result_ff.humidity_tenths,
                        out_result_ff.status};

endmodule

### test/sensor_frame_crc_checker_unit_tb.sv
// Self-checking testbench for the sensor frame CRC checker: random frames, stalls, scoreboard.
module sensor_frame_crc_checker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Abort the run if it drags on far past the slowest legal schedule.
   localparam int CYCLE_LIMIT    = 200000;
   localparam int TARGET_BYTES   = 1200;
   localparam int LONG_HOLD_LEN  = 400;
   localparam int DRAIN_CYCLES   = 8;

   // One byte of a sensor response frame as it goes out on req_*.
   typedef struct {
      logic [sfcc_pkg::BYTE_W-1:0] data;
      logic                        last;
      logic                        fault;
   } frame_byte_type;

   // What the checker must report for one finished frame.
   typedef struct {
      logic [sfcc_pkg::STATUS_W-1:0] status;
      logic [sfcc_pkg::WORD_W-1:0]   humidity;
      logic [sfcc_pkg::WORD_W-1:0]   temperature;
      logic [sfcc_pkg::CRC_W-1:0]    crc;
   } frame_verdict_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [sfcc_pkg::BYTE_W-1:0]   req_tdata  = '0;   // [7:0] data_byte
   logic                          req_tlast  = 1'b0; // last_byte
   logic                          req_tuser  = 1'b0; // [0] bus_fault
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [sfcc_pkg::RSP_W-1:0]    rsp_tdata;         // [1:0] status, [17:2] humidity_tenths,
                                                     // [33:18] temperature_tenths,
                                                     // [49:34] computed_crc, [55:50] zero

   frame_byte_type                pending_bytes[$];  // bytes still to be offered on req_*
   frame_verdict_type             verdicts_due[$];   // verdicts not yet seen on rsp_*
   logic [sfcc_pkg::BYTE_W-1:0]   frame_buf[$];      // frame under construction

   // Shadow of the checker's frame state.
   logic [sfcc_pkg::CRC_W-1:0]    crc_acc;
   logic [sfcc_pkg::BYTE_W-1:0]   held_lo;
   logic [sfcc_pkg::BYTE_W-1:0]   held_hi;
   logic [sfcc_pkg::POS_W-1:0]    byte_pos;
   logic [sfcc_pkg::WORD_W-1:0]   hum_cap;
   logic [sfcc_pkg::WORD_W-1:0]   temp_cap;
   logic                          fault_seen;

   int                  fail_count     = 0;
   int                  bytes_accepted = 0;
   int                  results_seen   = 0;
   int                  frames_queued  = 0;
   int                  send_gap       = 0;
   int                  rsp_hold       = 0;
   int                  cycle_count    = 0;
   logic                long_hold      = 1'b0;

   sensor_frame_crc_checker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 2 ns clock: one delay high, one low.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Reflected CRC-16, eight bit steps per byte.
   function automatic logic [sfcc_pkg::CRC_W-1:0] crc16_absorb(
         input logic [sfcc_pkg::CRC_W-1:0] crc,
         input logic [sfcc_pkg::BYTE_W-1:0] b);
      logic [sfcc_pkg::CRC_W-1:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ sfcc_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Return the shadow frame state to its post-reset values.
   task automatic clear_frame_state();
      crc_acc    = sfcc_pkg::CRC_START;
      held_lo    = '0;
      held_hi    = '0;
      byte_pos   = '0;
      hum_cap    = '0;
      temp_cap   = '0;
      fault_seen = 1'b0;
   endtask

   // Advance the shadow state by one accepted byte; on the final byte, queue the verdict.
   task automatic absorb_byte(input logic [sfcc_pkg::BYTE_W-1:0] b, input logic last,
                              input logic fault);
      frame_verdict_type v;
      logic [sfcc_pkg::POS_W-1:0] pos;
      pos = byte_pos;
      if (fault) fault_seen = 1'b1;
      // The oldest held byte is no longer a candidate for the trailing CRC pair.
      if (pos >= sfcc_pkg::POS_CRC_MIN) crc_acc = crc16_absorb(crc_acc, held_lo);
      held_lo = held_hi;
      held_hi = b;
      case (pos)
         sfcc_pkg::POS_HUM_HI:  hum_cap[15:8]  = b;
         sfcc_pkg::POS_HUM_LO:  hum_cap[7:0]   = b;
         sfcc_pkg::POS_TEMP_HI: temp_cap[15:8] = b;
         sfcc_pkg::POS_TEMP_LO: temp_cap[7:0]  = b;
         default: ;
      endcase
      if (pos != sfcc_pkg::POS_MAX) byte_pos = pos + 1'b1;
      if (last) begin
         // Bus fault wins over everything; short frames fail the CRC check.
         if (fault_seen)
            v.status = sfcc_pkg::STATUS_NO_SENSE;
         else if (pos < sfcc_pkg::POS_CRC_MIN)
            v.status = sfcc_pkg::STATUS_CRC_ERR;
         else if (held_lo == crc_acc[7:0] && held_hi == crc_acc[15:8])
            v.status = sfcc_pkg::STATUS_OK;
         else
            v.status = sfcc_pkg::STATUS_CRC_ERR;
         v.humidity    = hum_cap;
         v.temperature = temp_cap;
         v.crc         = crc_acc;
         verdicts_due.push_back(v);
         clear_frame_state();
      end
   endtask

   // Turn frame_buf into queued bytes: append the CRC if with_crc (corrupted if spoil_crc),
   // mark the final byte, and raise bus_fault on byte fault_at (-1 for none).
   task automatic queue_frame(input bit with_crc, input bit spoil_crc, input int fault_at);
      frame_byte_type item;
      logic [sfcc_pkg::CRC_W-1:0] crc;
      int n;
      crc = sfcc_pkg::CRC_START;
      if (with_crc) begin
         foreach (frame_buf[i]) crc = crc16_absorb(crc, frame_buf[i]);
         if (spoil_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
         frame_buf.push_back(crc[7:0]);
         frame_buf.push_back(crc[15:8]);
      end
      n = frame_buf.size();
      for (int i = 0; i < n; i++) begin
         item.data  = frame_buf[i];
         item.last  = (i == n - 1);
         item.fault = (i == fault_at);
         pending_bytes.push_back(item);
      end
      frame_buf.delete();
      frames_queued++;
   endtask

   // Driver: present the next byte once the current one is taken and the drawn gap expires.
   always @(posedge clock) begin : drive_req
      frame_byte_type nxt;
      logic take_next;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         take_next = !req_tvalid;
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata, req_tlast, req_tuser);
            bytes_accepted++;
            // Every third stretch of bytes goes back to back with no gaps.
            send_gap  = ((bytes_accepted / 97) % 3 == 0) ? 0 : $urandom_range(0, 6);
            take_next = 1'b1;
         end
         if (take_next) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               nxt = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tlast  <= nxt.last;
               req_tuser  <= nxt.fault;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: score each result transaction against the oldest verdict, then draw a stall.
   always @(posedge clock) begin : watch_rsp
      frame_verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               $error("unexpected result transaction: rsp_tdata=%h", rsp_tdata);
               fail_count++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
                  fail_count++;
               end
               if (rsp_tdata[17:2] !== want.humidity) begin
                  $error("humidity_tenths: expected %h, got %h", want.humidity,
                         rsp_tdata[17:2]);
                  fail_count++;
               end
               if (rsp_tdata[33:18] !== want.temperature) begin
                  $error("temperature_tenths: expected %h, got %h", want.temperature,
                         rsp_tdata[33:18]);
                  fail_count++;
               end
               if (rsp_tdata[49:34] !== want.crc) begin
                  $error("computed_crc: expected %h, got %h", want.crc, rsp_tdata[49:34]);
                  fail_count++;
               end
            end
            results_seen++;
            // Every third stretch of results is taken without stalls.
            rsp_hold = ((results_seen / 11) % 3 == 0) ? 0 : $urandom_range(0, 6);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !long_hold;
         end
      end
   end

   // Long back-pressure: hold off the result side while bytes keep coming,
   // so a final byte parks in the input register and req_tready drops.
   initial begin : long_stall
      while (results_seen < 25) @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_LEN) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sensor_frame_crc_checker_unit verification failed");
         $finish;
      end
   end

   // Build the stimulus, release reset, wait for the scoreboard to drain, report.
   initial begin : main_flow
      int kind;
      int body_len;
      int frame_no;
      clear_frame_state();

      // Directed frames.
      // One-byte frame: too short for a CRC.
      frame_buf = {8'hFF};
      queue_frame(1'b0, 1'b0, -1);
      // Two-byte frame: still too short.
      frame_buf = {8'h00, 8'hFF};
      queue_frame(1'b0, 1'b0, -1);
      // Shortest frame that can pass: one body byte plus CRC.
      frame_buf = {8'h00};
      queue_frame(1'b1, 1'b0, -1);
      // Full sensor response, extreme readings, good CRC.
      frame_buf = {8'h03, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
      queue_frame(1'b1, 1'b0, -1);
      // Opposite extremes with a corrupted CRC: raw values still reported.
      frame_buf = {8'h03, 8'h04, 8'h00, 8'h00, 8'hFF, 8'hFF};
      queue_frame(1'b1, 1'b1, -1);
      // Bus fault only on the final byte overrides a good CRC.
      frame_buf = {8'h01};
      queue_frame(1'b1, 1'b0, 2);

      // Random frames, mostly well formed with random content.
      frame_no = 0;
      while (pending_bytes.size() < TARGET_BYTES) begin
         kind = $urandom_range(0, 99);
         if (frame_no == 7 || frame_no == 60) begin
            // Long frame: position counter saturates, CRC keeps running.
            body_len = $urandom_range(254, 300);
            kind     = (frame_no == 7) ? 0 : 70;
         end else if (kind < 85) begin
            body_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 6;
         end else if (kind < 93) begin
            body_len = $urandom_range(1, 2);
         end else begin
            body_len = $urandom_range(3, 12);
         end
         for (int i = 0; i < body_len; i++) begin
            if ($urandom_range(0, 7) == 0)
               frame_buf.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
            else
               frame_buf.push_back(8'($urandom_range(0, 255)));
         end
         if (kind < 60)
            queue_frame(1'b1, 1'b0, -1);
         else if (kind < 75)
            queue_frame(1'b1, 1'b1, -1);
         else if (kind < 85)
            queue_frame(1'b1, 1'b0, $urandom_range(0, body_len + 1));
         else
            queue_frame(1'b0, 1'b0,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, body_len - 1) : -1);
         frame_no++;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Drain: wait until every queued frame has produced its result, then a short settle.
      while (results_seen < frames_queued)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && verdicts_due.size() == 0 && pending_bytes.size() == 0)
         $display("sensor_frame_crc_checker_unit verification clean");
      else
         $display("sensor_frame_crc_checker_unit verification failed");
      $finish;
   end

endmodule

### sim.f
src/sfcc_pkg.sv
src/sfcc_crc_step.sv
src/sfcc_frame_state.sv
src/sensor_frame_crc_checker_unit.sv
test/sensor_frame_crc_checker_unit_tb.sv
